// ----- src/morse_stream_decoder_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the Morse stream decoder
// Implication checks in the same cycle and in the next cycle, with reset.
// ----------------------------------------------------------------------------
`ifndef MORSE_STREAM_DECODER_ASSERT_SVH
`define MORSE_STREAM_DECODER_ASSERT_SVH

// The consequent must hold in the cycle of the antecedent.
`define MSD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("morse_stream_decoder: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define MSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("morse_stream_decoder: next-cycle check failed");

`endif

// ----- src/msd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Morse stream decoder package
// Table geometry, character codes and result kinds.
// ----------------------------------------------------------------------------
package msd_pkg;

    // Depth of the code tree; the heap holds 2^(MAX_DEPTH+1) entries.
    localparam int MAX_DEPTH  = 6;
    localparam int ADDR_W     = MAX_DEPTH + 1;
    localparam int TABLE_SIZE = 1 << ADDR_W;

    // Longest code a load may carry: limited by the tree and by the code field.
    localparam int          LOAD_LIM   = (MAX_DEPTH < 6) ? MAX_DEPTH : 6;
    localparam logic [2:0]  LOAD_LIM_W = 3'(LOAD_LIM);

    localparam logic [ADDR_W-1:0] ROOT_POS = ADDR_W'(1);

    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_DASH    = 8'h2D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;

    localparam logic FUNC_DECODE = 1'b0;
    localparam logic FUNC_LOAD   = 1'b1;

    typedef logic [1:0] t_kind;

    localparam t_kind K_LETTER  = 2'd0;
    localparam t_kind K_SPACE   = 2'd1;
    localparam t_kind K_NEWLINE = 2'd2;

endpackage

// ----- src/morse_stream_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Morse stream decoder
// Walks a heap-ordered letter table with dots and dashes and emits letters,
// word spaces and newlines.
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  --------+--------------------+-----------------------------------------------
//  input   | i_valid / o_stall  | i_func i_symbol i_end_of_text i_letter
//          |                    | i_code_bits i_code_len
//  output  | o_valid / i_stall  | o_out_char o_error o_last
//
//  One input transaction is taken per cycle while o_stall is low; the tree
//  position is updated and the letter table read in the cycle of acceptance.
//  A result passes through the result stage and then the output register.
//  A newline yields two results and holds the single result stage until both
//  have moved on to the output register.
//  Reset clears the table at once through per-entry valid bits; no sweep.
//  A stalled output holds the result register; input is taken while it waits
//  until the result stage behind it is full as well.
// ----------------------------------------------------------------------------

`include "morse_stream_decoder_assert.svh"

module morse_stream_decoder
    import msd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_func,
    input  logic [7:0]  i_symbol,
    input  logic        i_end_of_text,
    input  logic [7:0]  i_letter,
    input  logic [5:0]  i_code_bits,
    input  logic [2:0]  i_code_len,

    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_out_char,
    output logic        o_error,
    output logic        o_last
);

    // Letter table and its valid bits.
    logic [7:0]            r_table [TABLE_SIZE];
    logic [TABLE_SIZE-1:0] r_tbl_vld;

    // Decode state.
    logic [ADDR_W-1:0] r_pos, n_pos;
    logic              r_prev, n_prev;
    logic              r_ovf, n_ovf;

    // Result stage: up to two pending results and the table read data.
    logic        r_s1_valid;
    logic        r_s1_two;
    t_kind       r_s1_kind0, r_s1_kind1;
    logic        r_s1_err;
    logic [7:0]  r_rd_data;
    logic        r_rd_vld;

    // Output register.
    logic        r_o_valid;
    logic [7:0]  r_o_char;
    logic        r_o_err;
    logic        r_o_last;

    logic        accept, dec_acc, load_acc, load_ok;
    logic        out_free, push, s1_done, s1_load;
    logic        is_dot, is_dash, is_sp, is_sl, is_nl, deep;
    logic [ADDR_W-1:0] pos_w, pos1, rd_addr;
    logic        ovf1, char_letter, eot_emit;
    logic [1:0]  c_n, n_res;
    t_kind       c_kind0, kind0, kind1;
    logic        res_err;
    logic [6:0]  ld_onehot, ld_idx;
    logic [ADDR_W-1:0] wr_addr;
    t_kind       cur_kind;

    assign out_free = !r_o_valid || !i_stall;
    assign push     = r_s1_valid && out_free;
    assign s1_done  = push && !r_s1_two;
    assign o_stall  = r_s1_valid && !s1_done;
    assign accept   = i_valid && !o_stall;
    assign dec_acc  = accept && (i_func == FUNC_DECODE);
    assign load_acc = accept && (i_func == FUNC_LOAD);

    // Load address: a leading one marks the code length in the heap index.
    assign ld_onehot = 7'(1) << i_code_len;
    assign ld_idx    = ld_onehot | ({1'b0, i_code_bits} & (ld_onehot - 7'(1)));
    assign wr_addr   = ADDR_W'(ld_idx);
    assign load_ok   = (i_code_len <= LOAD_LIM_W);

    always_comb begin
        is_dot  = (i_symbol == CH_DOT);
        is_dash = (i_symbol == CH_DASH);
        is_sp   = (i_symbol == CH_SPACE);
        is_sl   = (i_symbol == CH_SLASH);
        is_nl   = (i_symbol == CH_NEWLINE);

        // A step below the deepest level keeps the position and flags overflow.
        deep  = r_pos[MAX_DEPTH];
        pos_w = deep ? r_pos : {r_pos[ADDR_W-2:0], is_dash};

        pos1        = r_pos;
        ovf1        = r_ovf;
        char_letter = 1'b0;
        c_n         = 2'd0;
        c_kind0     = K_LETTER;

        if (is_dot || is_dash) begin
            pos1 = pos_w;
            ovf1 = r_ovf | deep;
        end else if (is_sp) begin
            if (r_pos != ROOT_POS) begin
                char_letter = 1'b1;
                c_n         = 2'd1;
                pos1        = ROOT_POS;
                ovf1        = 1'b0;
            end
        end else if (is_sl) begin
            if (r_prev) begin
                c_n     = 2'd1;
                c_kind0 = K_SPACE;
            end
        end else if (is_nl) begin
            char_letter = 1'b1;
            c_n         = 2'd2;
            pos1        = ROOT_POS;
            ovf1        = 1'b0;
        end

        eot_emit = i_end_of_text && (pos1 != ROOT_POS);

        n_pos  = eot_emit ? ROOT_POS : pos1;
        n_ovf  = eot_emit ? 1'b0 : ovf1;
        n_prev = is_sp && !i_end_of_text;

        // At most one letter per transaction, so one table read serves it.
        rd_addr = char_letter ? r_pos : pos1;
        res_err = char_letter ? r_ovf : ovf1;

        n_res = c_n + {1'b0, eot_emit};
        kind0 = (c_n != 2'd0) ? c_kind0 : K_LETTER;
        kind1 = (c_n == 2'd2) ? K_NEWLINE : K_LETTER;
    end

    assign s1_load = dec_acc && (n_res != 2'd0);

    // Decode state and table valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= ROOT_POS;
            r_prev    <= 1'b0;
            r_ovf     <= 1'b0;
            r_tbl_vld <= '0;
        end else begin
            if (dec_acc) begin
                r_pos  <= n_pos;
                r_prev <= n_prev;
                r_ovf  <= n_ovf;
            end
            if (load_acc && load_ok) begin
                r_tbl_vld[wr_addr] <= 1'b1;
            end
        end
    end

    // Table memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (load_acc && load_ok) begin
            r_table[wr_addr] <= i_letter;
        end
        if (s1_load) begin
            r_rd_data <= r_table[rd_addr];
            r_rd_vld  <= r_tbl_vld[rd_addr];
        end
    end

    // Result stage control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_two   <= 1'b0;
        end else begin
            if (s1_load) begin
                r_s1_valid <= 1'b1;
                r_s1_two   <= (n_res == 2'd2);
            end else if (s1_done) begin
                r_s1_valid <= 1'b0;
            end else if (push) begin
                r_s1_two <= 1'b0;
            end
        end
    end

    // Result stage payload; the second result moves up once the first is gone.
    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r_s1_kind0 <= kind0;
            r_s1_kind1 <= kind1;
            r_s1_err   <= res_err;
        end else if (push) begin
            r_s1_kind0 <= r_s1_kind1;
        end
    end

    assign cur_kind = r_s1_kind0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (push) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            unique case (cur_kind)
                K_SPACE: begin
                    r_o_char <= CH_SPACE;
                    r_o_err  <= 1'b0;
                end
                K_NEWLINE: begin
                    r_o_char <= CH_NEWLINE;
                    r_o_err  <= 1'b0;
                end
                default: begin
                    r_o_char <= r_rd_vld ? r_rd_data : 8'h00;
                    r_o_err  <= r_s1_err;
                end
            endcase
            r_o_last <= !r_s1_two;
        end
    end

    assign o_valid    = r_o_valid;
    assign o_out_char = r_o_char;
    assign o_error    = r_o_err;
    assign o_last     = r_o_last;

    // A full result stage that cannot drain must hold off the input.
    `MSD_ASSERT_NOW(a_hold_input, i_clk, i_rst_n, r_s1_valid && r_o_valid && i_stall, o_stall)
    // The second of two results stays queued after the first one leaves.
    `MSD_ASSERT_NEXT(a_second_kept, i_clk, i_rst_n, push && r_s1_two, r_s1_valid)
    // A newline always brings the walk back to the root.
    `MSD_ASSERT_NEXT(a_nl_root, i_clk, i_rst_n, dec_acc && is_nl, r_pos == ROOT_POS)
    // The result stage is only refilled when it is empty or being emptied.
    `MSD_ASSERT_NOW(a_no_overwrite, i_clk, i_rst_n, s1_load, !r_s1_valid || s1_done)

endmodule
